### hw/rtl/cse_pkg.sv
`default_nettype none

package cse_pkg;

  localparam logic [3:0] BLANK_DIGIT = 4'd10;
  localparam logic [3:0] LAST_STEP   = 4'd10;

  typedef enum logic [2:0] {
    MODE_BLINK = 3'd0,
    MODE_SET   = 3'd1,
    MODE_PLUS  = 3'd2,
    MODE_MINUS = 3'd3,
    MODE_ENTER = 3'd4,
    MODE_LOAD  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_TIME = 2'd1,
    WR_DATE = 2'd2
  } write_kind_t;

  localparam logic [3:0] STEP_IDLE   = 4'd0;
  localparam logic [3:0] STEP_HOUR   = 4'd1;
  localparam logic [3:0] STEP_MINUTE = 4'd2;
  localparam logic [3:0] STEP_SECOND = 4'd3;
  localparam logic [3:0] STEP_DAY    = 4'd4;
  localparam logic [3:0] STEP_MONTH  = 4'd5;
  localparam logic [3:0] STEP_YEAR   = 4'd6;
  localparam logic [3:0] STEP_LZERO  = 4'd7;
  localparam logic [3:0] STEP_SEP    = 4'd8;
  localparam logic [3:0] STEP_BLIGHT = 4'd9;
  localparam logic [3:0] STEP_MIX    = 4'd10;

  typedef struct packed {
    logic [2:0] mode;
    logic       blink_on;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } item_t;

  typedef struct packed {
    logic [3:0]      step;
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic [4:0]      day;
    logic [3:0]      month;
    logic [6:0]      year;
    logic            lead_zero;
    logic            separator_on;
    logic [2:0]      backlight_mode;
    logic [6:0]      mix_delay;
    logic [5:0][3:0] tubes;
  } state_t;

  typedef struct packed {
    write_kind_t kind;
    logic [6:0]  a;
    logic [6:0]  b;
    logic [6:0]  c;
  } write_t;

endpackage

`default_nettype wire

### hw/rtl/cse_in_if.sv
`default_nettype none

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       blink_on;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;
  logic [4:0] load_day;
  logic [3:0] load_month;
  logic [6:0] load_year;

  modport source (
    output valid, mode, blink_on, load_hour, load_minute, load_second,
           load_day, load_month, load_year,
    input  ready
  );
  modport sink (
    input  valid, mode, blink_on, load_hour, load_minute, load_second,
           load_day, load_month, load_year,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cse_out_if.sv
`default_nettype none

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  tube0;
  logic [3:0]  tube1;
  logic [3:0]  tube2;
  logic [3:0]  tube3;
  logic [3:0]  tube4;
  logic [3:0]  tube5;
  logic [3:0]  edit_step;
  logic [1:0]  write_kind;
  logic [6:0]  write_a;
  logic [6:0]  write_b;
  logic [6:0]  write_c;
  logic [11:0] prefs_word;

  modport source (
    output valid, tube0, tube1, tube2, tube3, tube4, tube5, edit_step,
           write_kind, write_a, write_b, write_c, prefs_word,
    input  ready
  );
  modport sink (
    input  valid, tube0, tube1, tube2, tube3, tube4, tube5, edit_step,
           write_kind, write_a, write_b, write_c, prefs_word,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/clock_setting_editor_core.sv
// throughput: one beat per cycle unless the output stalls, set by
// the single step-update stage; a beat reaches its result through
// (input register, next-state logic, state and result register)
// an output stall holds the state and back-pressures the input register
// reset: synchronous, clears valids; time 00:00:00, date 01/01/00,
// prefs off with mix delay 10, all tubes blank, step 0
`default_nettype none

module clock_setting_editor_core (
  input  wire       clk,
  input  wire       rst,
  cse_in_if.sink    in_ch,
  cse_out_if.source out_ch
);

  logic            s1_valid;
  cse_pkg::item_t  s1_item;
  logic            out_valid;
  cse_pkg::state_t state;
  cse_pkg::state_t state_next;
  cse_pkg::write_t wr;
  cse_pkg::write_t wr_next;
  logic            s2_ready;
  logic            in_accept;

  assign s2_ready     = !out_valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || s2_ready;
  assign in_accept    = in_ch.valid && in_ch.ready;

  cse_step u_step (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .wr   (wr_next)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.mode        <= in_ch.mode;
      s1_item.blink_on    <= in_ch.blink_on;
      s1_item.load_hour   <= in_ch.load_hour;
      s1_item.load_minute <= in_ch.load_minute;
      s1_item.load_second <= in_ch.load_second;
      s1_item.load_day    <= in_ch.load_day;
      s1_item.load_month  <= in_ch.load_month;
      s1_item.load_year   <= in_ch.load_year;
    end
    if (s1_valid && s2_ready) wr <= wr_next;
    if (rst) begin
      s1_valid             <= 1'b0;
      out_valid            <= 1'b0;
      state.step           <= cse_pkg::STEP_IDLE;
      state.hour           <= '0;
      state.minute         <= '0;
      state.second         <= '0;
      state.day            <= 5'd1;
      state.month          <= 4'd1;
      state.year           <= '0;
      state.lead_zero      <= 1'b0;
      state.separator_on   <= 1'b0;
      state.backlight_mode <= '0;
      state.mix_delay      <= 7'd10;
      state.tubes          <= {6{cse_pkg::BLANK_DIGIT}};
    end else begin
      if (in_accept) s1_valid <= 1'b1;
      else if (s2_ready) s1_valid <= 1'b0;
      if (s1_valid && s2_ready) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.tube0      = state.tubes[0];
  assign out_ch.tube1      = state.tubes[1];
  assign out_ch.tube2      = state.tubes[2];
  assign out_ch.tube3      = state.tubes[3];
  assign out_ch.tube4      = state.tubes[4];
  assign out_ch.tube5      = state.tubes[5];
  assign out_ch.edit_step  = state.step;
  assign out_ch.write_kind = wr.kind;
  assign out_ch.write_a    = wr.a;
  assign out_ch.write_b    = wr.b;
  assign out_ch.write_c    = wr.c;
  assign out_ch.prefs_word = {state.mix_delay, state.backlight_mode,
                              state.separator_on, state.lead_zero};

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state.step <= cse_pkg::LAST_STEP)
    else $error("edit step out of range");

  a_time_write_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && wr.kind == cse_pkg::WR_TIME |->
      state.step == cse_pkg::STEP_MINUTE || state.step == cse_pkg::STEP_SECOND ||
      state.step == cse_pkg::STEP_DAY)
    else $error("time write with wrong step");

  a_date_write_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && wr.kind == cse_pkg::WR_DATE |->
      state.step == cse_pkg::STEP_YEAR || state.step == cse_pkg::STEP_MONTH ||
      state.step == cse_pkg::STEP_LZERO)
    else $error("date write with wrong step");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(state))
    else $error("state changed during output stall");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid)
    else $error("input stage dropped a beat");

endmodule

`default_nettype wire

### hw/rtl/cse_step.sv
`default_nettype none

module cse_step (
  input  wire cse_pkg::state_t cur,
  input  wire cse_pkg::item_t  item,
  output cse_pkg::state_t      nxt,
  output cse_pkg::write_t      wr
);

  function automatic logic [3:0] tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units(input logic [6:0] v);
    logic [6:0] u;
    u = v - 7'(tens(v)) * 7'd10;
    return u[3:0];
  endfunction

  function automatic logic [5:0][3:0] show_group(input cse_pkg::state_t s,
                                                 input logic [3:0] stp);
    logic [5:0][3:0] t;
    t = s.tubes;
    if (stp <= cse_pkg::STEP_SECOND) begin
      t[0] = tens(7'(s.hour));   t[1] = units(7'(s.hour));
      t[2] = tens(7'(s.minute)); t[3] = units(7'(s.minute));
      t[4] = tens(7'(s.second)); t[5] = units(7'(s.second));
    end else if (stp <= cse_pkg::STEP_YEAR) begin
      t[0] = tens(7'(s.day));    t[1] = units(7'(s.day));
      t[2] = tens(7'(s.month));  t[3] = units(7'(s.month));
      t[4] = tens(s.year);       t[5] = units(s.year);
    end else begin
      t[0] = 4'(s.lead_zero);
      t[1] = 4'(s.separator_on);
      t[2] = tens(7'(s.backlight_mode)); t[3] = units(7'(s.backlight_mode));
      t[4] = tens(s.mix_delay);          t[5] = units(s.mix_delay);
    end
    return t;
  endfunction

  function automatic logic [5:0][3:0] refresh(input cse_pkg::state_t s,
                                              input logic on);
    logic [5:0][3:0] t;
    logic [6:0]      v;
    t = s.tubes;
    case (s.step)
      cse_pkg::STEP_HOUR:   v = 7'(s.hour);
      cse_pkg::STEP_MINUTE: v = 7'(s.minute);
      cse_pkg::STEP_SECOND: v = 7'(s.second);
      cse_pkg::STEP_DAY:    v = 7'(s.day);
      cse_pkg::STEP_MONTH:  v = 7'(s.month);
      cse_pkg::STEP_YEAR:   v = s.year;
      cse_pkg::STEP_BLIGHT: v = 7'(s.backlight_mode);
      cse_pkg::STEP_MIX:    v = s.mix_delay;
      default:              v = '0;
    endcase
    case (s.step)
      cse_pkg::STEP_HOUR, cse_pkg::STEP_DAY: begin
        t[0] = on ? tens(v) : cse_pkg::BLANK_DIGIT;
        t[1] = on ? units(v) : cse_pkg::BLANK_DIGIT;
      end
      cse_pkg::STEP_MINUTE, cse_pkg::STEP_MONTH, cse_pkg::STEP_BLIGHT: begin
        t[2] = on ? tens(v) : cse_pkg::BLANK_DIGIT;
        t[3] = on ? units(v) : cse_pkg::BLANK_DIGIT;
      end
      cse_pkg::STEP_SECOND, cse_pkg::STEP_YEAR, cse_pkg::STEP_MIX: begin
        t[4] = on ? tens(v) : cse_pkg::BLANK_DIGIT;
        t[5] = on ? units(v) : cse_pkg::BLANK_DIGIT;
      end
      cse_pkg::STEP_LZERO: t[0] = on ? 4'(s.lead_zero) : cse_pkg::BLANK_DIGIT;
      cse_pkg::STEP_SEP:   t[1] = on ? 4'(s.separator_on) : cse_pkg::BLANK_DIGIT;
      default: ;
    endcase
    return t;
  endfunction

  function automatic cse_pkg::state_t edit_plus(input cse_pkg::state_t s);
    cse_pkg::state_t r;
    r = s;
    case (s.step)
      cse_pkg::STEP_HOUR:   r.hour = (s.hour >= 5'd23) ? 5'd0 : s.hour + 5'd1;
      cse_pkg::STEP_MINUTE: r.minute = (s.minute >= 6'd59) ? 6'd0 : s.minute + 6'd1;
      cse_pkg::STEP_SECOND: r.second = '0;
      cse_pkg::STEP_DAY:    r.day = (s.day >= 5'd31) ? 5'd1 : s.day + 5'd1;
      cse_pkg::STEP_MONTH:  r.month = (s.month >= 4'd12) ? 4'd1 : s.month + 4'd1;
      cse_pkg::STEP_YEAR:   r.year = (s.year >= 7'd99) ? 7'd0 : s.year + 7'd1;
      cse_pkg::STEP_LZERO:  r.lead_zero = 1'b1;
      cse_pkg::STEP_SEP:    r.separator_on = 1'b1;
      cse_pkg::STEP_BLIGHT: if (s.backlight_mode < 3'd6) r.backlight_mode = s.backlight_mode + 3'd1;
      cse_pkg::STEP_MIX:    if (s.mix_delay < 7'd99) r.mix_delay = s.mix_delay + 7'd1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic cse_pkg::state_t edit_minus(input cse_pkg::state_t s);
    cse_pkg::state_t r;
    r = s;
    case (s.step)
      cse_pkg::STEP_HOUR:
        r.hour = (s.hour == 5'd0 || s.hour > 5'd23) ? 5'd23 : s.hour - 5'd1;
      cse_pkg::STEP_MINUTE:
        r.minute = (s.minute == 6'd0 || s.minute > 6'd59) ? 6'd59 : s.minute - 6'd1;
      cse_pkg::STEP_SECOND: r.second = '0;
      cse_pkg::STEP_DAY:
        r.day = (s.day <= 5'd1 || s.day > 5'd31) ? 5'd31 : s.day - 5'd1;
      cse_pkg::STEP_MONTH:
        r.month = (s.month <= 4'd1 || s.month > 4'd12) ? 4'd12 : s.month - 4'd1;
      cse_pkg::STEP_YEAR:
        r.year = (s.year == 7'd0 || s.year > 7'd99) ? 7'd99 : s.year - 7'd1;
      cse_pkg::STEP_LZERO:  r.lead_zero = 1'b0;
      cse_pkg::STEP_SEP:    r.separator_on = 1'b0;
      cse_pkg::STEP_BLIGHT: if (s.backlight_mode > 3'd0) r.backlight_mode = s.backlight_mode - 3'd1;
      cse_pkg::STEP_MIX:    if (s.mix_delay > 7'd10) r.mix_delay = s.mix_delay - 7'd1;
      default: ;
    endcase
    return r;
  endfunction

  logic            editing;
  logic [3:0]      step_inc;
  cse_pkg::state_t edited;

  assign editing  = (cur.step != cse_pkg::STEP_IDLE);
  assign step_inc = cur.step + 4'd1;

  always_comb begin
    nxt    = cur;
    wr     = '0;
    wr.kind = cse_pkg::WR_NONE;
    edited = cur;
    case (item.mode)
      cse_pkg::MODE_BLINK: begin
        if (editing) nxt.tubes = refresh(cur, item.blink_on);
      end
      cse_pkg::MODE_SET: begin
        if (editing) begin
          if (cur.step <= cse_pkg::STEP_SECOND) begin
            wr.kind = cse_pkg::WR_TIME;
            wr.a = 7'(cur.hour); wr.b = 7'(cur.minute); wr.c = 7'(cur.second);
          end else if (cur.step <= cse_pkg::STEP_YEAR) begin
            wr.kind = cse_pkg::WR_DATE;
            wr.a = 7'(cur.day); wr.b = 7'(cur.month); wr.c = cur.year;
          end
          nxt.tubes = show_group(cur, step_inc);
          nxt.step  = (step_inc > cse_pkg::LAST_STEP) ? cse_pkg::STEP_IDLE : step_inc;
        end
      end
      cse_pkg::MODE_PLUS: begin
        if (editing) begin
          edited = edit_plus(cur);
          nxt = edited;
          nxt.tubes = refresh(edited, item.blink_on);
        end
      end
      cse_pkg::MODE_MINUS: begin
        if (editing) begin
          edited = edit_minus(cur);
          nxt = edited;
          nxt.tubes = refresh(edited, item.blink_on);
        end
      end
      cse_pkg::MODE_ENTER: begin
        nxt.step  = cse_pkg::STEP_HOUR;
        nxt.tubes = show_group(cur, cse_pkg::STEP_HOUR);
      end
      cse_pkg::MODE_LOAD: begin
        if (!editing) begin
          nxt.hour   = (item.load_hour > 5'd23) ? 5'd0 : item.load_hour;
          nxt.minute = (item.load_minute > 6'd59) ? 6'd0 : item.load_minute;
          nxt.second = (item.load_second > 6'd59) ? 6'd0 : item.load_second;
          nxt.day    = (item.load_day == 5'd0 || item.load_day > 5'd31) ? 5'd1 : item.load_day;
          nxt.month  = (item.load_month == 4'd0 || item.load_month > 4'd12) ?
                       4'd1 : item.load_month;
          nxt.year   = (item.load_year > 7'd99) ? 7'd0 : item.load_year;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [0:5][3:0] tubes;
    logic [3:0]      step;
    logic [1:0]      kind;
    logic [6:0]      a;
    logic [6:0]      b;
    logic [6:0]      c;
    logic [11:0]     prefs;
  } display_beat_t;

  logic clk = 1'b0;
  logic rst;

  cse_in_if  ev_if ();
  cse_out_if dp_if ();

  clock_setting_editor_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (ev_if),
    .out_ch (dp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted editor state
  logic [3:0]      ed_step;
  logic [4:0]      ed_hour;
  logic [5:0]      ed_minute;
  logic [5:0]      ed_second;
  logic [4:0]      ed_day;
  logic [3:0]      ed_month;
  logic [6:0]      ed_year;
  logic            ed_lzero;
  logic            ed_sep;
  logic [2:0]      ed_blight;
  logic [6:0]      ed_mix;
  logic [0:5][3:0] shown;

  cse_pkg::item_t pend_q[$];
  display_beat_t  display_due[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  in_taken;
  bit  hold_req;
  int  hold_left;
  int  quiet;
  int  mismatches;
  int  events_queued;
  int  events_in;
  int  displays_out;
  int  clock_writes;
  int  in_stalls;

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  task automatic show_pair(input int pos, input logic [6:0] v, input bit on);
    if (on) begin
      shown[pos]     = 4'(v / 7'd10);
      shown[pos + 1] = 4'(v % 7'd10);
    end else begin
      shown[pos]     = cse_pkg::BLANK_DIGIT;
      shown[pos + 1] = cse_pkg::BLANK_DIGIT;
    end
  endtask

  task automatic show_group();
    if (ed_step <= cse_pkg::STEP_SECOND) begin
      show_pair(0, 7'(ed_hour), 1'b1);
      show_pair(2, 7'(ed_minute), 1'b1);
      show_pair(4, 7'(ed_second), 1'b1);
    end else if (ed_step <= cse_pkg::STEP_YEAR) begin
      show_pair(0, 7'(ed_day), 1'b1);
      show_pair(2, 7'(ed_month), 1'b1);
      show_pair(4, ed_year, 1'b1);
    end else begin
      shown[0] = {3'b000, ed_lzero};
      shown[1] = {3'b000, ed_sep};
      show_pair(2, 7'(ed_blight), 1'b1);
      show_pair(4, ed_mix, 1'b1);
    end
  endtask

  task automatic refresh_field(input bit on);
    case (ed_step)
      cse_pkg::STEP_HOUR:   show_pair(0, 7'(ed_hour), on);
      cse_pkg::STEP_MINUTE: show_pair(2, 7'(ed_minute), on);
      cse_pkg::STEP_SECOND: show_pair(4, 7'(ed_second), on);
      cse_pkg::STEP_DAY:    show_pair(0, 7'(ed_day), on);
      cse_pkg::STEP_MONTH:  show_pair(2, 7'(ed_month), on);
      cse_pkg::STEP_YEAR:   show_pair(4, ed_year, on);
      cse_pkg::STEP_LZERO:  shown[0] = on ? {3'b000, ed_lzero} : cse_pkg::BLANK_DIGIT;
      cse_pkg::STEP_SEP:    shown[1] = on ? {3'b000, ed_sep} : cse_pkg::BLANK_DIGIT;
      cse_pkg::STEP_BLIGHT: show_pair(2, 7'(ed_blight), on);
      cse_pkg::STEP_MIX:    show_pair(4, ed_mix, on);
      default: ;
    endcase
  endtask

  task automatic bump_field(input bit up);
    case (ed_step)
      cse_pkg::STEP_HOUR:
        ed_hour = up ? ((ed_hour >= 23) ? 5'd0 : ed_hour + 5'd1)
                     : ((ed_hour == 0 || ed_hour > 23) ? 5'd23 : ed_hour - 5'd1);
      cse_pkg::STEP_MINUTE:
        ed_minute = up ? ((ed_minute >= 59) ? 6'd0 : ed_minute + 6'd1)
                       : ((ed_minute == 0 || ed_minute > 59) ? 6'd59 : ed_minute - 6'd1);
      cse_pkg::STEP_SECOND: ed_second = '0;
      cse_pkg::STEP_DAY:
        ed_day = up ? ((ed_day >= 31) ? 5'd1 : ed_day + 5'd1)
                    : ((ed_day <= 1 || ed_day > 31) ? 5'd31 : ed_day - 5'd1);
      cse_pkg::STEP_MONTH:
        ed_month = up ? ((ed_month >= 12) ? 4'd1 : ed_month + 4'd1)
                      : ((ed_month <= 1 || ed_month > 12) ? 4'd12 : ed_month - 4'd1);
      cse_pkg::STEP_YEAR:
        ed_year = up ? ((ed_year >= 99) ? 7'd0 : ed_year + 7'd1)
                     : ((ed_year == 0 || ed_year > 99) ? 7'd99 : ed_year - 7'd1);
      cse_pkg::STEP_LZERO: ed_lzero = up;
      cse_pkg::STEP_SEP:   ed_sep = up;
      cse_pkg::STEP_BLIGHT: begin
        if (up && ed_blight < 6) ed_blight = ed_blight + 3'd1;
        else if (!up && ed_blight > 0) ed_blight = ed_blight - 3'd1;
      end
      cse_pkg::STEP_MIX: begin
        if (up && ed_mix < 99) ed_mix = ed_mix + 7'd1;
        else if (!up && ed_mix > 10) ed_mix = ed_mix - 7'd1;
      end
      default: ;
    endcase
  endtask

  task automatic predict_display(input cse_pkg::item_t ev);
    display_beat_t due;
    due = '0;
    due.kind = cse_pkg::WR_NONE;
    case (ev.mode)
      cse_pkg::MODE_BLINK: if (ed_step != cse_pkg::STEP_IDLE) refresh_field(ev.blink_on);
      cse_pkg::MODE_SET: if (ed_step != cse_pkg::STEP_IDLE) begin
        if (ed_step <= cse_pkg::STEP_SECOND) begin
          due.kind = cse_pkg::WR_TIME;
          due.a = 7'(ed_hour);
          due.b = 7'(ed_minute);
          due.c = 7'(ed_second);
        end else if (ed_step <= cse_pkg::STEP_YEAR) begin
          due.kind = cse_pkg::WR_DATE;
          due.a = 7'(ed_day);
          due.b = 7'(ed_month);
          due.c = ed_year;
        end
        ed_step = ed_step + 4'd1;
        show_group();
        if (ed_step > cse_pkg::LAST_STEP) ed_step = cse_pkg::STEP_IDLE;
      end
      cse_pkg::MODE_PLUS, cse_pkg::MODE_MINUS: if (ed_step != cse_pkg::STEP_IDLE) begin
        bump_field(ev.mode == cse_pkg::MODE_PLUS);
        refresh_field(ev.blink_on);
      end
      cse_pkg::MODE_ENTER: begin
        ed_step = cse_pkg::STEP_HOUR;
        show_group();
      end
      cse_pkg::MODE_LOAD: if (ed_step == cse_pkg::STEP_IDLE) begin
        ed_hour   = (ev.load_hour > 23) ? 5'd0 : ev.load_hour;
        ed_minute = (ev.load_minute > 59) ? 6'd0 : ev.load_minute;
        ed_second = (ev.load_second > 59) ? 6'd0 : ev.load_second;
        ed_day    = (ev.load_day == 0 || ev.load_day > 31) ? 5'd1 : ev.load_day;
        ed_month  = (ev.load_month == 0 || ev.load_month > 12) ? 4'd1 : ev.load_month;
        ed_year   = (ev.load_year > 99) ? 7'd0 : ev.load_year;
      end
      default: ;
    endcase
    due.tubes = shown;
    due.step  = ed_step;
    due.prefs = {ed_mix, ed_blight, ed_sep, ed_lzero};
    display_due.push_back(due);
  endtask

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s on display beat %0d: expected %0d, got %0d",
                 name, displays_out, want, got);
    end
  endtask

  // beat bookkeeping and comparison
  always @(posedge clk) begin : scoreboard
    cse_pkg::item_t seen;
    display_beat_t  got;
    display_beat_t  want;
    in_taken <= !rst && ev_if.valid && ev_if.ready;
    if (!rst && dp_if.valid && dp_if.ready) begin
      got.tubes = {dp_if.tube0, dp_if.tube1, dp_if.tube2,
                   dp_if.tube3, dp_if.tube4, dp_if.tube5};
      got.step  = dp_if.edit_step;
      got.kind  = dp_if.write_kind;
      got.a     = dp_if.write_a;
      got.b     = dp_if.write_b;
      got.c     = dp_if.write_c;
      got.prefs = dp_if.prefs_word;
      displays_out++;
      if (got.kind != cse_pkg::WR_NONE) clock_writes++;
      if (display_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected display beat %0d: step %0d", displays_out, got.step);
      end else begin
        want = display_due.pop_front();
        for (int i = 0; i < 6; i++)
          check_field($sformatf("tube%0d", i), 12'(want.tubes[i]), 12'(got.tubes[i]));
        check_field("edit_step", 12'(want.step), 12'(got.step));
        check_field("write_kind", 12'(want.kind), 12'(got.kind));
        check_field("write_a", 12'(want.a), 12'(got.a));
        check_field("write_b", 12'(want.b), 12'(got.b));
        check_field("write_c", 12'(want.c), 12'(got.c));
        check_field("prefs_word", want.prefs, got.prefs);
      end
    end
    if (!rst && ev_if.valid && !ev_if.ready) in_stalls++;
    if (!rst && ev_if.valid && ev_if.ready) begin
      seen.mode        = ev_if.mode;
      seen.blink_on    = ev_if.blink_on;
      seen.load_hour   = ev_if.load_hour;
      seen.load_minute = ev_if.load_minute;
      seen.load_second = ev_if.load_second;
      seen.load_day    = ev_if.load_day;
      seen.load_month  = ev_if.load_month;
      seen.load_year   = ev_if.load_year;
      events_in++;
      predict_display(seen);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((ev_if.valid && ev_if.ready) || (dp_if.valid && dp_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  always @(negedge clk) begin : event_driver
    cse_pkg::item_t nxt;
    if (!rst && (!ev_if.valid || in_taken)) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_q.pop_front();
        ev_if.valid       <= 1'b1;
        ev_if.mode        <= nxt.mode;
        ev_if.blink_on    <= nxt.blink_on;
        ev_if.load_hour   <= nxt.load_hour;
        ev_if.load_minute <= nxt.load_minute;
        ev_if.load_second <= nxt.load_second;
        ev_if.load_day    <= nxt.load_day;
        ev_if.load_month  <= nxt.load_month;
        ev_if.load_year   <= nxt.load_year;
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  // long output hold-off
  always @(negedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    if (rst || hold_left != 0) dp_if.ready <= 1'b0;
    else dp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic cse_pkg::item_t rand_item();
    logic [63:0]    r;
    cse_pkg::item_t it;
    r  = {$urandom, $urandom};
    it = r[$bits(cse_pkg::item_t)-1:0];
    return it;
  endfunction

  function automatic cse_pkg::item_t make_event(input logic [2:0] mode, input bit on);
    cse_pkg::item_t it;
    it = rand_item();
    it.mode = mode;
    it.blink_on = on;
    return it;
  endfunction

  function automatic cse_pkg::item_t make_load(input logic [4:0] h, input logic [5:0] mi,
                                               input logic [5:0] s, input logic [4:0] d,
                                               input logic [3:0] mo, input logic [6:0] y);
    cse_pkg::item_t it;
    it = make_event(cse_pkg::MODE_LOAD, coin());
    it.load_hour   = h;
    it.load_minute = mi;
    it.load_second = s;
    it.load_day    = d;
    it.load_month  = mo;
    it.load_year   = y;
    return it;
  endfunction

  task automatic enqueue(input cse_pkg::item_t it);
    pend_q.push_back(it);
    events_queued++;
  endtask

  // enter, walk the ten steps with edits, sometimes abandon midway
  task automatic queue_session();
    int         quit_at;
    int         burst;
    logic [2:0] dir;
    quit_at = ($urandom_range(19) == 0) ? int'($urandom_range(1, 10)) : 11;
    enqueue(make_event(cse_pkg::MODE_ENTER, coin()));
    for (int s = 1; s <= 10; s++) begin
      dir = coin() ? cse_pkg::MODE_PLUS : cse_pkg::MODE_MINUS;
      if (s >= 9 && $urandom_range(7) == 0) begin
        burst = int'($urandom_range(60, 100));
        repeat (burst) enqueue(make_event(dir, coin()));
      end else begin
        burst = int'($urandom_range(4));
        repeat (burst) begin
          case ($urandom_range(3))
            0: enqueue(make_event(cse_pkg::MODE_BLINK, coin()));
            1: enqueue(make_event(cse_pkg::MODE_PLUS, coin()));
            2: enqueue(make_event(cse_pkg::MODE_MINUS, coin()));
            default: enqueue(make_event(dir, coin()));
          endcase
        end
      end
      if (s == quit_at) return;
      enqueue(make_event(cse_pkg::MODE_SET, coin()));
    end
  endtask

  task automatic queue_random(input int upto);
    int r;
    while (events_queued < upto) begin
      r = int'($urandom_range(99));
      if (r < 60) begin
        queue_session();
      end else if (r < 80) begin
        if ($urandom_range(3) == 0)
          enqueue(make_event(cse_pkg::MODE_LOAD, coin()));
        else
          enqueue(make_load(5'($urandom_range(23)), 6'($urandom_range(59)),
                            6'($urandom_range(59)), 5'($urandom_range(1, 31)),
                            4'($urandom_range(1, 12)), 7'($urandom_range(99))));
      end else begin
        enqueue(make_event(3'($urandom_range(7)), coin()));
      end
    end
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pend_q.size() != 0 || ev_if.valid) @(posedge clk);
    @(negedge clk);
    while (display_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst               = 1'b1;
    ev_if.valid       = 1'b0;
    ev_if.mode        = cse_pkg::MODE_BLINK;
    ev_if.blink_on    = 1'b0;
    ev_if.load_hour   = '0;
    ev_if.load_minute = '0;
    ev_if.load_second = '0;
    ev_if.load_day    = '0;
    ev_if.load_month  = '0;
    ev_if.load_year   = '0;
    dp_if.ready       = 1'b0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_req          = 1'b0;
    hold_left         = 0;
    quiet             = 0;
    mismatches        = 0;
    events_queued     = 0;
    events_in         = 0;
    displays_out      = 0;
    clock_writes      = 0;
    in_stalls         = 0;
    in_taken          = 1'b0;
    ed_step   = cse_pkg::STEP_IDLE;
    ed_hour   = '0;
    ed_minute = '0;
    ed_second = '0;
    ed_day    = 5'd1;
    ed_month  = 4'd1;
    ed_year   = '0;
    ed_lzero  = 1'b0;
    ed_sep    = 1'b0;
    ed_blight = '0;
    ed_mix    = 7'd10;
    for (int i = 0; i < 6; i++) shown[i] = cse_pkg::BLANK_DIGIT;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    start_phase(30, 72);
    // running: these are ignored
    enqueue(make_event(cse_pkg::MODE_BLINK, 1'b1));
    enqueue(make_event(MODE_SPARE_HI, 1'b1));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_PLUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b0));
    // load fields out of range take defaults; the third load sits at the top of each range
    enqueue(make_load(5'd31, 6'd63, 6'd63, 5'd0, 4'd15, 7'd127));
    enqueue(make_load(5'd24, 6'd60, 6'd60, 5'd31, 4'd0, 7'd100));
    enqueue(make_load(5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 7'd99));
    enqueue(make_event(cse_pkg::MODE_ENTER, 1'b1));
    enqueue(make_event(cse_pkg::MODE_PLUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b0));
    enqueue(make_event(cse_pkg::MODE_BLINK, 1'b1));
    enqueue(make_load(5'd1, 6'd2, 6'd3, 5'd4, 4'd5, 7'd6));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_PLUS, 1'b0));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b0));
    enqueue(make_event(cse_pkg::MODE_PLUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_PLUS, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b1));
    repeat (4) enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_MINUS, 1'b0));
    enqueue(make_event(cse_pkg::MODE_SET, 1'b1));
    enqueue(make_event(cse_pkg::MODE_ENTER, 1'b0));
    enqueue(make_event(cse_pkg::MODE_ENTER, 1'b1));
    queue_random(360);
    drain();

    start_phase(72, 30);
    queue_random(690);
    drain();

    start_phase(0, 0);
    queue_random(1030);
    @(negedge clk) hold_req <= 1'b1;
    @(negedge clk) hold_req <= 1'b0;
    drain();

    repeat (8) @(negedge clk);
    mismatches += display_due.size();
    $display("run covered %0d event beats and %0d display beats, %0d of them clock writes",
             events_in, displays_out, clock_writes);
    $display("input was stalled for %0d cycles, %0d field mismatches",
             in_stalls, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
